### hdl/mqttd_pkg.sv
// Shared types and codes for the MQTT packet deframer.
package mqttd_pkg;

  // Byte width of the stream and widths of the tagged result fields
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned REGION_W = 3;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned LEN_W    = 28;
  localparam int unsigned HDR_W    = 17;
  localparam int unsigned USER_W   = 16;

  // Region tags carried on the result stream
  typedef enum logic [REGION_W-1:0] {
    REGION_FIXED    = 3'd0,
    REGION_LENGTH   = 3'd1,
    REGION_VAR_HDR  = 3'd2,
    REGION_PAYLOAD  = 3'd3,
    REGION_UNPARSED = 3'd4
  } region_t;

  // Control packet types that get their body parsed
  localparam logic [KIND_W-1:0] KIND_CONNACK = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PUBLISH = 4'd3;

  // Reset value of the section size limit
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd128;

  // Fixed size of the CONNACK variable header and the PUBLISH topic length field
  localparam logic [HDR_W-1:0] FIXED_HDR_BYTES = 17'd2;

endpackage

### hdl/mqtt_packet_deframer.sv
// MQTT packet deframer: tags each stream byte with its packet region.
//
// Usage: raw MQTT bytes enter on the in_ stream, one byte per request. Each
// byte comes back on the out_ stream with its region (fixed header, length,
// variable header, payload, unparsed), the packet type, an end-of-packet
// mark on tlast and length/oversize error flags on tuser.
// cfg_wr_en loads section_limit from cfg_wr_data; write it only while the
// block is idle.
// Pipeline: an input request passes through the input register, then the
// result register. Throughput: one byte per cycle while out_tready is high;
// the next packet state (length accumulator, byte counters, phase) is
// computed combinationally between the two registers.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to the start of a packet and sets section_limit to 128.
// Backpressure: while out_tready is low the result register holds; the input
// register still takes one more byte, then in_tready drops until the result
// is taken.
module mqtt_packet_deframer #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // section_limit
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_in
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // [7:0] data_out
  output logic        out_tlast,     // end_of_packet
  output logic [15:0] out_tuser      // [2:0] region, [6:3] packet_kind,
                                     // [7] length_error, [8] oversize, rest 0
);

  typedef enum logic [2:0] {
    PH_FIXED = 3'd0,
    PH_LEN   = 3'd1,
    PH_TOPIC = 3'd2,
    PH_PAY   = 3'd3,
    PH_UNP   = 3'd4,
    PH_VAR   = 3'd5
  } phase_t;

  localparam logic [2:0] LAST_DIGIT = 3'(MAX_LENGTH_BYTES);

  // configuration register
  logic [mqttd_pkg::LIMIT_W-1:0] section_limit_r;

  // input register
  logic                         in_valid_r;
  logic [mqttd_pkg::BYTE_W-1:0] in_data_r;

  // parser state
  phase_t                        phase_r, phase_nxt;
  logic [mqttd_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [1:0]                    digit_r, digit_nxt;
  logic [mqttd_pkg::LEN_W-1:0]   acc_r, acc_nxt;
  logic [mqttd_pkg::LEN_W-1:0]   left_r, left_nxt;
  logic [mqttd_pkg::HDR_W-1:0]   hdr_left_r, hdr_left_nxt;
  logic [mqttd_pkg::BYTE_W-1:0]  topic_high_r, topic_high_nxt;

  // result register
  logic                          out_valid_r;
  logic [mqttd_pkg::BYTE_W-1:0]  out_data_r;
  mqttd_pkg::region_t            out_region_r, region_nxt;
  logic [mqttd_pkg::KIND_W-1:0]  out_kind_r;
  logic                          out_eop_r, eop_nxt;
  logic                          out_lerr_r, lerr_nxt;
  logic                          out_over_r, over_nxt;

  // helper values
  logic                          advance;
  logic                          cont;
  logic                          last_digit;
  logic [4:0]                    shamt;
  logic [mqttd_pkg::LEN_W-1:0]   acc_or;
  logic [mqttd_pkg::LEN_W-1:0]   left_dec;
  logic [15:0]                   topic;
  logic                          topic_gt;
  logic [mqttd_pkg::HDR_W-1:0]   hdr_sel;
  logic [mqttd_pkg::HDR_W-1:0]   hdr_dec;

  // handshake: the input register moves on when the result register is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // length digit: 7 data bits placed at 7 * digit index
  assign cont       = in_data_r[7];
  assign last_digit = ({1'b0, digit_r} + 3'd1) >= LAST_DIGIT;
  assign shamt      = ({3'd0, digit_r} << 3) - {3'd0, digit_r};
  assign acc_or     = acc_r | (mqttd_pkg::LEN_W'(in_data_r[6:0]) << shamt);

  // body counters and topic length checks
  assign left_dec = left_r - 28'd1;
  assign topic    = {topic_high_r, in_data_r};
  assign topic_gt = {12'd0, topic} > left_dec;
  assign hdr_sel  = topic_gt ? left_dec[mqttd_pkg::HDR_W-1:0] : {1'b0, topic};
  assign hdr_dec  = (hdr_left_r != '0) ? hdr_left_r - 17'd1 : hdr_left_r;

  // per-byte parse step
  always_comb begin
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    digit_nxt      = digit_r;
    acc_nxt        = acc_r;
    left_nxt       = left_r;
    hdr_left_nxt   = hdr_left_r;
    topic_high_nxt = topic_high_r;
    region_nxt     = mqttd_pkg::REGION_UNPARSED;
    eop_nxt        = 1'b0;
    lerr_nxt       = 1'b0;
    over_nxt       = 1'b0;

    case (phase_r)
      PH_FIXED: begin
        region_nxt = mqttd_pkg::REGION_FIXED;
        kind_nxt   = in_data_r[7:4];
        digit_nxt  = 2'd0;
        acc_nxt    = '0;
        phase_nxt  = PH_LEN;
      end
      PH_LEN: begin
        region_nxt = mqttd_pkg::REGION_LENGTH;
        acc_nxt    = acc_or;
        if (cont && !last_digit) begin
          digit_nxt = digit_r + 2'd1;
        end else begin
          // length complete (a continuation on the last digit is an error)
          lerr_nxt = cont;
          left_nxt = acc_or;
          if (acc_or == '0) begin
            eop_nxt   = 1'b1;
            phase_nxt = PH_FIXED;
          end else if (kind_r == mqttd_pkg::KIND_CONNACK) begin
            if (acc_or < 28'd2) begin
              hdr_left_nxt = acc_or[mqttd_pkg::HDR_W-1:0];
              lerr_nxt     = 1'b1;
            end else begin
              hdr_left_nxt = mqttd_pkg::FIXED_HDR_BYTES;
            end
            over_nxt  = section_limit_r < 16'd2;
            phase_nxt = PH_VAR;
          end else if (kind_r == mqttd_pkg::KIND_PUBLISH) begin
            hdr_left_nxt = mqttd_pkg::FIXED_HDR_BYTES;
            if (acc_or < 28'd2) begin
              lerr_nxt = 1'b1;
            end
            phase_nxt = PH_TOPIC;
          end else begin
            phase_nxt = PH_UNP;
          end
        end
      end
      default: begin
        // body byte
        left_nxt = left_dec;
        eop_nxt  = (left_dec == '0);
        case (phase_r)
          PH_TOPIC: begin
            region_nxt = mqttd_pkg::REGION_VAR_HDR;
            if (hdr_left_r >= mqttd_pkg::FIXED_HDR_BYTES) begin
              topic_high_nxt = in_data_r;
              hdr_left_nxt   = 17'd1;
            end else begin
              // topic length known: size the variable header and payload
              lerr_nxt     = topic_gt;
              over_nxt     = (({1'b0, topic} + 17'd2) > {1'b0, section_limit_r}) ||
                             ((left_dec - mqttd_pkg::LEN_W'(hdr_sel)) >
                              mqttd_pkg::LEN_W'(section_limit_r));
              hdr_left_nxt = hdr_sel;
              phase_nxt    = (hdr_sel != '0) ? PH_VAR : PH_PAY;
            end
          end
          PH_VAR: begin
            region_nxt   = mqttd_pkg::REGION_VAR_HDR;
            hdr_left_nxt = hdr_dec;
            if (hdr_dec == '0) begin
              phase_nxt = (kind_r == mqttd_pkg::KIND_PUBLISH) ? PH_PAY : PH_UNP;
            end
          end
          PH_PAY: begin
            region_nxt = mqttd_pkg::REGION_PAYLOAD;
          end
          default: begin
            region_nxt = mqttd_pkg::REGION_UNPARSED;
            phase_nxt  = PH_UNP;
          end
        endcase
        if (eop_nxt) begin
          phase_nxt = PH_FIXED;
        end
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_limit_r <= mqttd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      section_limit_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIXED;
      kind_r       <= '0;
      digit_r      <= '0;
      acc_r        <= '0;
      left_r       <= '0;
      hdr_left_r   <= '0;
      topic_high_r <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      kind_r       <= kind_nxt;
      digit_r      <= digit_nxt;
      acc_r        <= acc_nxt;
      left_r       <= left_nxt;
      hdr_left_r   <= hdr_left_nxt;
      topic_high_r <= topic_high_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r   <= in_data_r;
      out_region_r <= region_nxt;
      out_kind_r   <= kind_nxt;
      out_eop_r    <= eop_nxt;
      out_lerr_r   <= lerr_nxt;
      out_over_r   <= over_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_eop_r;
  assign out_tuser  = {7'd0, out_over_r, out_lerr_r, out_kind_r, out_region_r};

endmodule

### verif/mqtt_packet_deframer_test.sv
// Self-checking testbench for the MQTT packet deframer: directed table, then random packets.
module mqtt_packet_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_DIGITS   = 4;
  localparam int unsigned PHASE_ITEMS  = 270;
  localparam int unsigned N_PHASES     = 5;
  localparam logic [3:0]  KIND_RESERVED = 4'd0;
  localparam logic [3:0]  KIND_AUTH     = 4'd15;

  // Parser position inside the current packet
  typedef enum logic [2:0] {
    P_HEAD, P_LEN, P_TOPIC, P_PAY, P_UNP, P_VAR
  } parse_phase_t;

  // One tagged byte as it should leave the block
  typedef struct packed {
    logic [7:0]         data;
    mqttd_pkg::region_t region;
    logic [3:0]         kind;
    logic               eop;
    logic               lerr;
    logic               over;
  } byte_tag_t;

  // Directed table row; the tag fields only count where typed is set
  typedef struct packed {
    logic [7:0]         b;
    logic               typed;
    mqttd_pkg::region_t region;
    logic [3:0]         kind;
    logic               eop;
    logic               lerr;
    logic               over;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [7:0] data_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] data_out
  logic        out_tlast;          // end_of_packet
  logic [15:0] out_tuser;          // [2:0] region, [6:3] packet_kind,
                                   // [7] length_error, [8] oversize

  // Sideband that travels with each request: typed expectation, if any
  logic        row_typed = 1'b0;
  byte_tag_t   row_want = '0;

  // Predictor state
  parse_phase_t ph = P_HEAD;
  logic [3:0]   cur_kind = '0;
  logic [1:0]   len_digit = '0;
  logic [27:0]  len_sum = '0;
  logic [27:0]  body_left = '0;
  logic [16:0]  hdr_left = '0;
  logic [7:0]   topic_msb = '0;
  logic [15:0]  limit_cfg = mqttd_pkg::LIMIT_RESET;

  byte_tag_t    expected_tags [$];
  int unsigned  mismatches = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  stall_left = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_stall_on = 1'b1;

  dir_row_t dir_rows [26] = '{
    // PUBLISH, topic of one byte, one payload byte
    '{8'h30, 1'b1, mqttd_pkg::REGION_FIXED,    mqttd_pkg::KIND_PUBLISH, 1'b0, 1'b0, 1'b0},
    '{8'h04, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h61, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, mqttd_pkg::REGION_PAYLOAD,  mqttd_pkg::KIND_PUBLISH, 1'b1, 1'b0, 1'b0},
    // CONNACK with one extra body byte
    '{8'h20, 1'b1, mqttd_pkg::REGION_FIXED,    mqttd_pkg::KIND_CONNACK, 1'b0, 1'b0, 1'b0},
    '{8'h03, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h99, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    // top kind, empty body
    '{8'hF0, 1'b1, mqttd_pkg::REGION_FIXED,    KIND_AUTH,               1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, mqttd_pkg::REGION_LENGTH,   KIND_AUTH,               1'b1, 1'b0, 1'b0},
    // kind 0, continuation still set on the last allowed length byte
    '{8'h0F, 1'b1, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, mqttd_pkg::REGION_LENGTH,   KIND_RESERVED,           1'b1, 1'b1, 1'b0},
    // PUBLISH with a one-byte body
    '{8'h3F, 1'b1, mqttd_pkg::REGION_FIXED,    mqttd_pkg::KIND_PUBLISH, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b1, mqttd_pkg::REGION_LENGTH,   mqttd_pkg::KIND_PUBLISH, 1'b0, 1'b1, 1'b0},
    '{8'hAB, 1'b1, mqttd_pkg::REGION_VAR_HDR,  mqttd_pkg::KIND_PUBLISH, 1'b1, 1'b0, 1'b0},
    // PUBLISH with the largest topic length, far past the body and the limit
    '{8'h30, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'h03, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, mqttd_pkg::REGION_FIXED,    KIND_RESERVED,           1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, mqttd_pkg::REGION_VAR_HDR,  mqttd_pkg::KIND_PUBLISH, 1'b0, 1'b1, 1'b1},
    '{8'h00, 1'b1, mqttd_pkg::REGION_VAR_HDR,  mqttd_pkg::KIND_PUBLISH, 1'b1, 1'b0, 1'b0}
  };

  mqtt_packet_deframer #(
    .MAX_LENGTH_BYTES(LEN_DIGITS)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always #5 clk = ~clk;

  // Tag one byte and advance the packet state
  function automatic byte_tag_t deframe_step(input logic [7:0] b);
    byte_tag_t   t;
    logic        cont;
    logic        last;
    int unsigned topic;
    int unsigned hl;
    t = '0;
    t.data = b;
    t.region = mqttd_pkg::REGION_UNPARSED;
    case (ph)
      P_HEAD: begin
        t.region = mqttd_pkg::REGION_FIXED;
        cur_kind = b[7:4];
        len_digit = '0;
        len_sum = '0;
        ph = P_LEN;
      end
      P_LEN: begin
        cont = b[7];
        last = (int'(len_digit) + 1 >= LEN_DIGITS);
        t.region = mqttd_pkg::REGION_LENGTH;
        len_sum = len_sum | (28'(b[6:0]) << (7 * len_digit));
        if (cont && !last) begin
          len_digit = len_digit + 2'd1;
        end else begin
          t.lerr = cont;
          body_left = len_sum;
          if (len_sum == 0) begin
            t.eop = 1'b1;
            ph = P_HEAD;
          end else if (cur_kind == mqttd_pkg::KIND_CONNACK) begin
            hdr_left = (len_sum < mqttd_pkg::FIXED_HDR_BYTES) ?
                       17'(len_sum) : mqttd_pkg::FIXED_HDR_BYTES;
            if (len_sum < mqttd_pkg::FIXED_HDR_BYTES) t.lerr = 1'b1;
            if (limit_cfg < mqttd_pkg::FIXED_HDR_BYTES) t.over = 1'b1;
            ph = P_VAR;
          end else if (cur_kind == mqttd_pkg::KIND_PUBLISH) begin
            hdr_left = mqttd_pkg::FIXED_HDR_BYTES;
            if (len_sum < mqttd_pkg::FIXED_HDR_BYTES) t.lerr = 1'b1;
            ph = P_TOPIC;
          end else begin
            ph = P_UNP;
          end
        end
      end
      default: begin
        body_left = body_left - 28'd1;
        t.eop = (body_left == 0);
        case (ph)
          P_TOPIC: begin
            t.region = mqttd_pkg::REGION_VAR_HDR;
            if (hdr_left >= mqttd_pkg::FIXED_HDR_BYTES) begin
              topic_msb = b;
              hdr_left = 17'd1;
            end else begin
              topic = {topic_msb, b};
              // a topic longer than the body swallows the rest as header
              if (topic > body_left) begin
                t.lerr = 1'b1;
                hl = body_left;
              end else begin
                hl = topic;
              end
              if (topic + mqttd_pkg::FIXED_HDR_BYTES > limit_cfg ||
                  body_left - hl > limit_cfg)
                t.over = 1'b1;
              hdr_left = 17'(hl);
              ph = (hdr_left != 0) ? P_VAR : P_PAY;
            end
          end
          P_VAR: begin
            t.region = mqttd_pkg::REGION_VAR_HDR;
            if (hdr_left != 0) hdr_left = hdr_left - 17'd1;
            if (hdr_left == 0) ph = (cur_kind == mqttd_pkg::KIND_PUBLISH) ? P_PAY : P_UNP;
          end
          P_PAY: t.region = mqttd_pkg::REGION_PAYLOAD;
          default: t.region = mqttd_pkg::REGION_UNPARSED;
        endcase
        if (t.eop) ph = P_HEAD;
      end
    endcase
    t.kind = cur_kind;
    return t;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // Short gaps mostly, a few long ones
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int unsigned pick_body_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 10);
    if (r < 90) return $urandom_range(11, 40);
    if (r < 98) return $urandom_range(41, 160);
    return $urandom_range(161, 400);
  endfunction

  // Prediction on accepted requests, checking on accepted results
  always @(posedge clk) begin
    byte_tag_t got;
    byte_tag_t want;
    if (rst_n) begin
      if (cfg_wr_en) limit_cfg = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        got = deframe_step(in_tdata);
        if (row_typed) got = row_want;
        expected_tags.push_back(got);
      end
      if (out_tvalid && out_tready) begin
        if (expected_tags.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual data %0h",
                   $time, out_tdata);
        end else begin
          want = expected_tags.pop_front();
          check_field("data", 16'(want.data), 16'(out_tdata));
          check_field("region", 16'(want.region), 16'(out_tuser[2:0]));
          check_field("kind", 16'(want.kind), 16'(out_tuser[6:3]));
          check_field("end_of_packet", 16'(want.eop), 16'(out_tlast));
          check_field("length_error", 16'(want.lerr), 16'(out_tuser[7]));
          check_field("oversize", 16'(want.over), 16'(out_tuser[8]));
          check_field("tuser spare", 16'd0, 16'(out_tuser[15:9]));
        end
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (stall_left == 0 && rx_stall_on && $urandom_range(0, 3) == 0)
      stall_left = pick_pause();
    out_tready <= (stall_left == 0);
    if (stall_left != 0) stall_left--;
  end

  // Offer one byte and hold it until the request is taken
  task automatic send_byte(input logic [7:0] b, input logic typed, input byte_tag_t want);
    int unsigned pause;
    pause = tx_idle_on ? pick_pause() : 0;
    if (pause != 0) begin
      in_tvalid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_raw(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  // Stop sending until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_tags.size() != 0);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One packet: mostly well formed, some with a run-on length field
  task automatic send_packet();
    int unsigned r;
    int unsigned body_len;
    int unsigned ndig;
    int unsigned topic;
    int unsigned i;
    logic [3:0]  kind;
    logic [7:0]  lb;
    bit          run_on;
    r = $urandom_range(0, 99);
    if (r < 35) kind = mqttd_pkg::KIND_PUBLISH;
    else if (r < 60) kind = mqttd_pkg::KIND_CONNACK;
    else kind = 4'($urandom_range(0, 15));
    run_on = ($urandom_range(0, 99) < 8);
    if (run_on) begin
      body_len = $urandom_range(0, 12);
      ndig = LEN_DIGITS;
    end else begin
      body_len = pick_body_len();
      ndig = (body_len < 128) ? 1 : 2;
      // padded encodings reach the upper digit positions
      if ($urandom_range(0, 3) == 0) ndig = $urandom_range(ndig, LEN_DIGITS);
    end
    send_raw({kind, 4'($urandom_range(0, 15))});
    for (i = 0; i < ndig; i++) begin
      lb = 8'((body_len >> (7 * i)) & 32'h7F);
      if (i + 1 < ndig || run_on) lb[7] = 1'b1;
      send_raw(lb);
    end
    if (kind == mqttd_pkg::KIND_PUBLISH && body_len >= 2) begin
      r = $urandom_range(0, 99);
      if (r < 75) topic = $urandom_range(0, body_len - 2);
      else if (r < 90) topic = $urandom_range(body_len - 1, 65535);
      else topic = $urandom_range(0, 65535);
      send_raw(8'(topic >> 8));
      send_raw(8'(topic));
      for (i = 2; i < body_len; i++) send_raw(8'($urandom_range(0, 255)));
    end else begin
      for (i = 0; i < body_len; i++) send_raw(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    byte_tag_t   want;
    int unsigned phase_no;
    int unsigned goal;
    int unsigned npk;
    logic [15:0] lim;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[k]) begin
      want = '{dir_rows[k].b, dir_rows[k].region, dir_rows[k].kind,
               dir_rows[k].eop, dir_rows[k].lerr, dir_rows[k].over};
      send_byte(dir_rows[k].b, dir_rows[k].typed, want);
    end

    // Random packets over several limit settings and idle mixes
    for (phase_no = 0; phase_no < N_PHASES; phase_no++) begin
      tx_idle_on = (phase_no != 1 && phase_no != 3);
      rx_stall_on = (phase_no != 1 && phase_no != 2);
      if (phase_no != 0) begin
        drain();
        case (phase_no)
          1: lim = 16'd1;
          2: lim = 16'hFFFF;
          3: lim = 16'($urandom_range(3, 64));
          default: lim = 16'd2;
        endcase
        write_limit(lim);
      end
      goal = bytes_sent + PHASE_ITEMS;
      npk = 0;
      while (bytes_sent < goal) begin
        send_packet();
        npk++;
        if (phase_no == 0 && npk == 5) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_tags.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
